@@ src/itrt_pkg.sv @@
// ----------------------------------------------------------------------------
// itrt_pkg: shared constants, types and helpers
// Sizes, character codes and the queue word used by the radix text unit.
// ----------------------------------------------------------------------------
`default_nettype none

package itrt_pkg;

  // Sizes
  localparam int VALUE_WIDTH = 32;
  localparam int DIGIT_DEPTH = 32;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 8;

  // Radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  // Divider: quotient bits retired per cycle
  localparam int STEP_BITS  = 4;
  localparam int DIV_CYCLES = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W      = DIV_CYCLES * STEP_BITS;
  localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Digit store addressing
  localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);
  localparam int IDX_W = $clog2(DIGIT_DEPTH);

  // Job queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h7a;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam int                DEC_DIGITS = 10;

  // One classified conversion job
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg;
    logic [RADIX_W-1:0]     base;
  } itrt_job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } itrt_q_status_t;

  // Digit value to lower-case ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DIGIT_W'(DEC_DIGITS)) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_A + dx - CHAR_W'(DEC_DIGITS);
  endfunction

endpackage

`default_nettype wire

@@ src/itrt_chan_if.sv @@
// ----------------------------------------------------------------------------
// itrt channel interfaces
// Valid/ready channels for the input word and the output character word.
// ----------------------------------------------------------------------------
`default_nettype none

interface itrt_in_if
  import itrt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic                   signed_mode;

  modport source (output valid, output value, output signed_mode, input ready);
  modport sink   (input valid, input value, input signed_mode, output ready);
endinterface

interface itrt_out_if
  import itrt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

@@ src/itrt_front.sv @@
// ----------------------------------------------------------------------------
// itrt_front: input acceptance and classification
// Holds the radix register, clamps it, takes the sign and magnitude of each
// input word and pushes the job into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module itrt_front
  import itrt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  itrt_in_if.sink              din,
  input  wire logic            cfg_we,
  input  wire logic [RADIX_W-1:0] cfg_wdata,
  input  wire itrt_q_status_t  q_status,
  output logic                 push,
  output itrt_job_t            push_data
);

  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] base;
  logic               neg;

  // Radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  // Saturate radix to the legal range
  always_comb begin
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
  end

  // Sign and magnitude; the magnitude is unsigned so the most negative value fits
  assign neg = din.signed_mode & din.value[VALUE_WIDTH-1];

  assign push_data.mag  = neg ? (~din.value + VALUE_WIDTH'(1)) : din.value;
  assign push_data.neg  = neg;
  assign push_data.base = base;

  // Accept while the queue has room
  assign din.ready = ~q_status.full;
  assign push      = din.valid & ~q_status.full;

endmodule

`default_nettype wire

@@ src/itrt_queue.sv @@
// ----------------------------------------------------------------------------
// itrt_queue: job queue between front and back
// Small register FIFO so that input acceptance and conversion stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module itrt_queue
  import itrt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire itrt_job_t push_data,
  input  wire logic      pop,
  output itrt_job_t      pop_data,
  output itrt_q_status_t status
);

  itrt_job_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign pop_data     = entries[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

@@ src/itrt_back.sv @@
// ----------------------------------------------------------------------------
// itrt_back: digit generation and character output
// Divides the magnitude by the radix STEP_BITS quotient bits a cycle, keeps
// the remainders in the digit store, then sends them out most significant
// first behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itrt_back
  import itrt_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire itrt_q_status_t q_status,
  input  wire itrt_job_t      q_data,
  output logic                pop,
  itrt_out_if.source          dout
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t             state;
  logic [PAD_W-1:0]   dividend;
  logic [DIGIT_W-1:0] rem;
  logic [RADIX_W-1:0] base;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   cnt;
  logic               sign_pend;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  logic [DIGIT_W-1:0] digit_store [DIGIT_DEPTH];

  logic [PAD_W-1:0]   dividend_next;
  logic [DIGIT_W-1:0] rem_next;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   cnt_dec;
  logic               last_step;
  logic               store_wr;
  logic               out_free;
  logic [DIGIT_W-1:0] rd_digit;

  // Four restoring division steps on a narrow remainder
  always_comb begin
    logic [DIGIT_W:0]      trial;
    logic [DIGIT_W-1:0]    r;
    logic [STEP_BITS-1:0]  qbits;
    r     = rem;
    qbits = '0;
    trial = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {r, dividend[PAD_W-1-i]};
      if (trial >= {1'b0, base}) begin
        r        = DIGIT_W'(trial - {1'b0, base});
        qbits[STEP_BITS-1-i] = 1'b1;
      end else begin
        r = trial[DIGIT_W-1:0];
      end
    end
    rem_next      = r;
    dividend_next = {dividend[PAD_W-STEP_BITS-1:0], qbits};
  end

  assign cnt_inc   = cnt + CNT_W'(1);
  assign cnt_dec   = cnt - CNT_W'(1);
  assign last_step = (step == STEP_W'(DIV_CYCLES - 1));
  assign store_wr  = (state == ST_DIV) && last_step;
  assign out_free  = ~out_valid | dout.ready;
  assign pop       = (state == ST_IDLE) && ~q_status.empty;
  assign rd_digit  = digit_store[cnt_dec[IDX_W-1:0]];

  // Digit store, remainders in order of discovery
  always_ff @(posedge clk) begin
    if (store_wr) begin
      digit_store[cnt[IDX_W-1:0]] <= rem_next;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      sign_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // word taken while nothing new is loaded
      if (out_valid && dout.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_status.empty) begin
            dividend  <= PAD_W'(q_data.mag);
            base      <= q_data.base;
            sign_pend <= q_data.neg;
            rem       <= '0;
            step      <= '0;
            cnt       <= '0;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (last_step) begin
            cnt <= cnt_inc;
            // stop on zero quotient or full store
            if (dividend_next == '0 || cnt_inc == CNT_W'(DIGIT_DEPTH)) begin
              state <= ST_EMIT;
            end else begin
              dividend <= dividend_next;
              rem      <= '0;
              step     <= '0;
            end
          end else begin
            dividend <= dividend_next;
            rem      <= rem_next;
            step     <= step + STEP_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (sign_pend) begin
              out_char  <= CHAR_MINUS;
              out_last  <= 1'b0;
              sign_pend <= 1'b0;
            end else begin
              out_char <= digit_char(rd_digit);
              out_last <= (cnt == CNT_W'(1));
              cnt      <= cnt_dec;
              if (cnt == CNT_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign dout.valid    = out_valid;
  assign dout.out_char = out_char;
  assign dout.last     = out_last;

endmodule

`default_nettype wire

@@ src/integer_to_radix_text_unit.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_text_unit: integer to ASCII text in radix 2..36
// Converts each input word to characters, most significant first, '-' ahead
// of a negative signed value, last character flagged.
// ----------------------------------------------------------------------------
//
//   port       dir   handshake      word
//   din        in    valid/ready    value[31:0], signed_mode
//   dout       out   valid/ready    out_char[7:0], last
//   cfg_we     in    write strobe   cfg_wdata[5:0] = radix
//
// A job leaves the queue, the divider finds its digits one after another, then
// the characters go out one per cycle while dout is ready. The divider is
// shared by all digits of a job, and the back end takes the next job only
// after the last character of this one is in its output register. Reset is
// synchronous and clears the control state; the radix returns to ten. A stalled
// dout holds the back end while the front keeps filling a two-word job queue.
//
`default_nettype none

module integer_to_radix_text_unit
  import itrt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  itrt_in_if.sink                 din,
  itrt_out_if.source              dout,
  input  wire logic               cfg_we,
  input  wire logic [RADIX_W-1:0] cfg_wdata
);

  itrt_q_status_t q_status;
  itrt_job_t      push_data;
  itrt_job_t      pop_data;
  logic           push;
  logic           pop;

  itrt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  itrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  itrt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_data   (pop_data),
    .pop      (pop),
    .dout     (dout)
  );

endmodule

`default_nettype wire

@@ src/itrt_checker.sv @@
// ----------------------------------------------------------------------------
// itrt_checker: port-level checks for the radix text unit
// Watches the output channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module itrt_checker
  import itrt_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              dout_valid,
  input wire logic              dout_ready,
  input wire logic [CHAR_W-1:0] out_char,
  input wire logic              last
);

  // Output stays quiet right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !dout_valid)
    else $error("dout valid right after reset");

  // A stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    dout_valid && !dout_ready |=> dout_valid)
    else $error("dout valid dropped while stalled");

  // Only sign, decimal digits and lower-case letters are produced
  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    dout_valid |-> (out_char == CHAR_MINUS) ||
                   (out_char >= CHAR_ZERO && out_char <= CHAR_NINE) ||
                   (out_char >= CHAR_A && out_char <= CHAR_Z))
    else $error("illegal character on dout");

  // The sign never ends a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    dout_valid && out_char == CHAR_MINUS |-> !last)
    else $error("minus sign flagged as last");

endmodule

bind integer_to_radix_text_unit itrt_checker u_itrt_checker (
  .clk        (clk),
  .rst        (rst),
  .dout_valid (dout.valid),
  .dout_ready (dout.ready),
  .out_char   (dout.out_char),
  .last       (dout.last)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for integer_to_radix_text_unit
// First a table of directed conversions at the radix extremes and around the
// sign bit, then random words in phases of random radix. Each accepted input
// word is turned into the expected character words by a local predictor or from
// a typed-in text, and each character word on dout is checked against the oldest expectation.
// ----------------------------------------------------------------------------

module tb_top;
  import itrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int          RANDOM_WORDS = 270;
  localparam int          TAIL_CYCLES  = 300;

  // One expected character word
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // One directed conversion; empty text means use the predictor
  typedef struct {
    logic [RADIX_W-1:0]     radix;
    logic [VALUE_WIDTH-1:0] value;
    logic                   sgn;
    string                  text;
  } conv_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [RADIX_W-1:0] cfg_wdata;

  itrt_in_if  din ();
  itrt_out_if dout ();

  text_char_t  expected_chars[$];
  int          errors = 0;
  int unsigned cycle_cnt = 0;

  // Sender pacing shared by every word sent
  int unsigned burst_left = 0;
  int unsigned gap_max = 3;
  logic [RADIX_W-1:0] radix_now;

  integer_to_radix_text_unit uut (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .dout      (dout),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected text of one conversion, appended to the expectation queue
  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value,
                                       input logic sgn,
                                       input logic [RADIX_W-1:0] radix);
    int unsigned            base;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg;
    logic [DIGIT_W-1:0]     digits[$];
    logic [DIGIT_W-1:0]     d;
    logic [CHAR_W-1:0]      ch;
    base = radix;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    neg = sgn && value[VALUE_WIDTH-1];
    mag = neg ? -value : value;
    // digits come out least significant first
    do begin
      d = DIGIT_W'(mag % base);
      digits.push_front(d);
      mag = mag / base;
    end while (mag != 0 && digits.size() < DIGIT_DEPTH);
    if (neg) expected_chars.push_back('{ch: CHAR_MINUS, last: 1'b0});
    for (int i = 0; i < digits.size(); i++) begin
      if (digits[i] < DEC_DIGITS) ch = CHAR_ZERO + CHAR_W'(digits[i]);
      else ch = CHAR_A + CHAR_W'(digits[i]) - CHAR_W'(DEC_DIGITS);
      expected_chars.push_back('{ch: ch, last: (i == digits.size() - 1)});
    end
  endfunction

  // Typed-in text, last flag on its final character
  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      expected_chars.push_back('{ch: s[i], last: (i == s.len() - 1)});
    end
  endfunction

  // Random word, weighted toward the sign bit and short texts
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return VALUE_WIDTH'($urandom);
      1: return VALUE_WIDTH'($urandom) >> $urandom_range(0, VALUE_WIDTH - 1);
      2: return -(VALUE_WIDTH'($urandom) >> $urandom_range(0, VALUE_WIDTH - 1));
      3: return 32'h8000_0000 ^ VALUE_WIDTH'($urandom_range(0, 3));
      4: return 32'hFFFF_FFFF ^ VALUE_WIDTH'($urandom_range(0, 3));
      default: return VALUE_WIDTH'($urandom_range(0, 40));
    endcase
  endfunction

  // Send one word in bursts; returns at the edge it is taken
  task automatic send_word(input logic [VALUE_WIDTH-1:0] v, input logic s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk);
        din.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    din.valid       <= 1'b1;
    din.value       <= v;
    din.signed_mode <= s;
    do @(posedge clk); while (!din.ready);
  endtask

  // Stop sending and wait for every expected character
  task automatic drain();
    @(negedge clk);
    din.valid <= 1'b0;
    burst_left = 0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we    <= 1'b0;
    radix_now = r;
  endtask

  // Stimulus: directed table, then random phases
  initial begin : stimulus
    conv_row_t              rows[$];
    logic [VALUE_WIDTH-1:0] v;
    logic                   s;
    int                     sent;
    int                     phase_len;
    logic [RADIX_W-1:0]     r;

    rst             = 1'b1;
    din.valid       = 1'b0;
    din.value       = '0;
    din.signed_mode = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    radix_now       = RADIX_RESET;

    // radix after reset
    rows.push_back('{6'd10, 32'h0000_0000, 1'b0, "0"});
    rows.push_back('{6'd10, 32'hFFFF_FFFF, 1'b0, "4294967295"});
    rows.push_back('{6'd10, 32'hFFFF_FFFF, 1'b1, "-1"});
    rows.push_back('{6'd10, 32'h8000_0000, 1'b1, "-2147483648"});
    rows.push_back('{6'd10, 32'h8000_0000, 1'b0, "2147483648"});
    rows.push_back('{6'd10, 32'h7FFF_FFFF, 1'b1, "2147483647"});
    rows.push_back('{6'd10, 32'd12345,     1'b1, "12345"});
    // longest texts
    rows.push_back('{6'd2,  32'hFFFF_FFFF, 1'b0, ""});
    rows.push_back('{6'd2,  32'h8000_0000, 1'b1, ""});
    rows.push_back('{6'd2,  32'h0000_0001, 1'b0, "1"});
    // letters up to 'z'
    rows.push_back('{6'd36, 32'hFFFF_FFFF, 1'b0, "1z141z3"});
    rows.push_back('{6'd36, 32'd35,        1'b0, "z"});
    rows.push_back('{6'd36, 32'd36,        1'b0, "10"});
    rows.push_back('{6'd36, 32'hFFFF_FFF1, 1'b1, "-f"});
    rows.push_back('{6'd16, 32'hDEAD_BEEF, 1'b0, "deadbeef"});
    rows.push_back('{6'd16, 32'hDEAD_BEEF, 1'b1, ""});
    // radix below two saturates to two, above 36 to 36; then radix 8 and 3
    rows.push_back('{6'd0,  32'd5,         1'b0, "101"});
    rows.push_back('{6'd1,  32'd2,         1'b0, "10"});
    rows.push_back('{6'd37, 32'd36,        1'b0, "10"});
    rows.push_back('{6'd63, 32'hFFFF_FFFF, 1'b0, "1z141z3"});
    rows.push_back('{6'd8,  32'hFFFF_FFFF, 1'b0, "37777777777"});
    rows.push_back('{6'd3,  32'hFFFF_FFFF, 1'b0, ""});

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].radix != radix_now) begin
        drain();
        write_radix(rows[i].radix);
      end
      send_word(rows[i].value, rows[i].sgn);
      if (rows[i].text.len() != 0) push_text(rows[i].text);
      else predict_text(rows[i].value, rows[i].sgn, radix_now);
    end

    // random phases, each at one radix and one sender pace
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      drain();
      if ($urandom_range(0, 7) == 0) r = RADIX_W'($urandom_range(0, 63));
      else r = RADIX_W'($urandom_range(2, 36));
      write_radix(r);
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      phase_len = $urandom_range(15, 40);
      for (int i = 0; i < phase_len && sent < RANDOM_WORDS; i++) begin
        v = pick_value();
        s = 1'($urandom_range(0, 1));
        send_word(v, s);
        predict_text(v, s, radix_now);
        sent++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver stall pattern: free-running, stalling at random, or long holds
  initial begin : ready_pattern
    int unsigned mode;
    int unsigned mode_cnt;
    int unsigned hold_cnt;
    logic        hold_level;
    mode       = 0;
    mode_cnt   = 0;
    hold_cnt   = 0;
    hold_level = 1'b0;
    dout.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_cnt == 0) begin
        mode     = $urandom_range(0, 2);
        mode_cnt = $urandom_range(50, 300);
      end
      mode_cnt--;
      case (mode)
        0: dout.ready <= 1'b1;
        1: dout.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (hold_cnt == 0) begin
            hold_level = ~hold_level;
            hold_cnt   = hold_level ? $urandom_range(1, 12) : $urandom_range(1, 20);
          end
          hold_cnt--;
          dout.ready <= hold_level;
        end
      endcase
    end
  end

  // Check each character word taken from dout
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && dout.valid && dout.ready) begin
      if (expected_chars.size() == 0) begin
        $error("out_char: expected none, got %h (last %b)", dout.out_char, dout.last);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (dout.out_char !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, dout.out_char);
          errors++;
        end
        if (dout.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, dout.last);
          errors++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
